@@ rtl/gss_pkg.sv @@
// Shared types and codes for the GOOSE subscription supervisor.
// Used by the supervisor top level and its port checker; no dependencies.
`default_nettype none

package gss_pkg;

	typedef enum logic [1:0] {
		OP_FRAME  = 2'd0,
		OP_EXPIRY = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_FIRST      = 4'd0,
		ST_RETRANSMIT = 4'd1,
		ST_CHANGE     = 4'd2,
		ST_JUMP       = 4'd3,
		ST_STATE_BACK = 4'd4,
		ST_DUPLICATE  = 4'd5,
		ST_SEQ_GAP    = 4'd6,
		ST_SEQ_BACK   = 4'd7,
		ST_IDENTITY   = 4'd8,
		ST_TIME_BACK  = 4'd9,
		ST_EXPIRED    = 4'd10,
		ST_NONE       = 4'd11,
		ST_COUNTER    = 4'd12,
		ST_CLEARED    = 4'd13
	} status_t;

	// Configuration register indexes
	localparam logic [1:0] REG_CHECK_ENABLE = 2'd0;
	localparam logic [1:0] REG_BLOCK_TAG    = 2'd1;
	localparam logic [1:0] REG_SET_TAG      = 2'd2;
	localparam logic [1:0] REG_REVISION     = 2'd3;

	// Statistics counter indexes
	localparam int NUM_COUNTERS  = 11;
	localparam int CNT_ACCEPTED  = 0;
	localparam int CNT_IDENTITY  = 1;
	localparam int CNT_RETX      = 2;
	localparam int CNT_CHANGE    = 3;
	localparam int CNT_DUP       = 4;
	localparam int CNT_GAP       = 5;
	localparam int CNT_SEQ_BACK  = 6;
	localparam int CNT_JUMP      = 7;
	localparam int CNT_ST_BACK   = 8;
	localparam int CNT_SAME_ST   = 9;
	localparam int CNT_EXPIRED   = 10;

	// Flag bits
	localparam int FLG_EXPIRED_BEFORE = 0;
	localparam int FLG_CHANGE_SEQ     = 1;
	localparam int FLG_VALUES         = 2;
	localparam int FLG_SAME_STATE     = 3;
	localparam int FLG_REVISION       = 4;

	// Fixed field widths
	localparam int FIELD_W   = 32;
	localparam int DIGEST_W  = 64;
	localparam int CIDX_W    = 4;
	localparam int FLAGS_W   = 5;
	localparam int MISSED_W  = 31;

	localparam logic [FIELD_W-1:0] HALF_RANGE = 32'h8000_0000;

endpackage

`default_nettype wire

@@ rtl/goose_subscription_supervisor.sv @@
// Supervisor for one GOOSE subscription (stNum/sqNum, time-to-live, statistics).
// Depends on gss_pkg for operation, status and counter codes.
//
// Usage:
//   s_axis carries one operation per item: tuser = op, tdata = frame fields.
//   m_axis returns exactly one result item per input item: tuser = status,
//   tdata = flags, missed count, aux value, deadline and expiry report.
//   cfg writes the check enables and expected tags; the user must do so only
//   while the block is idle, which the block does not enforce; cfg_ready is always high.
// Timing: an accepted item passes through the input register, then the result
//   register, where m_axis_tvalid rises. Throughput: one item per cycle while
//   m_axis_tready does not stall the result, set by the single pass of compares,
//   one time add and counter increments from the input register to the result
//   register and the subscription state.
// Reset (arst_n low) clears subscription state, all counters and the
//   registers. A clear item returns state and counters to reset, keeps the
//   registers.
// Stall: while m_axis_tready is low the result holds; one more item is taken
//   into the input register, after which s_axis_tready drops until the result
//   drains.
`default_nettype none

module goose_subscription_supervisor #(
	parameter int TIME_BITS    = 48,
	parameter int COUNTER_BITS = 32,
	localparam int IN_W  = ((TIME_BITS + 6 * 32 + 64 + 4 + 7) / 8) * 8,
	localparam int OUT_W = ((2 * TIME_BITS + 5 + 31 + 1 + 3 * 32 + 7) / 8) * 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// cfg channel
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_data,
	// input items
	input  wire logic             s_axis_tvalid,
	output logic                  s_axis_tready,
	// tdata: time_ms, frame_state, frame_sequence, frame_revision, frame_ttl_ms,
	//        values_digest, block_tag, set_tag, counter_index, zero pad
	input  wire logic [IN_W-1:0]  s_axis_tdata,
	// tuser: op
	input  wire logic [1:0]       s_axis_tuser,
	// result items
	output logic                  m_axis_tvalid,
	input  wire logic             m_axis_tready,
	// tdata: flags, missed_count, aux_value, deadline_armed, deadline_ms,
	//        report_state, report_sequence, report_ttl_ms, zero pad
	output logic [OUT_W-1:0]      m_axis_tdata,
	// tuser: status
	output logic [3:0]            m_axis_tuser
);

	localparam int FW = gss_pkg::FIELD_W;
	localparam int DW = gss_pkg::DIGEST_W;
	localparam int CW = gss_pkg::CIDX_W;
	localparam int NC = gss_pkg::NUM_COUNTERS;
	localparam int RES_W = 2 * TIME_BITS + gss_pkg::FLAGS_W + gss_pkg::MISSED_W + 1 + 3 * FW;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
	localparam logic [COUNTER_BITS-1:0] CNT_ONE = {{(COUNTER_BITS-1){1'b0}}, 1'b1};

	// configuration registers
	logic [2:0]    check_enable_q;
	logic [FW-1:0] exp_block_q, exp_set_q, exp_rev_q;

	// input register
	logic            valid_s1;
	gss_pkg::op_t    op_s1;
	logic [IN_W-1:0] data_s1;

	// result register
	logic             out_valid_q;
	logic [3:0]       status_q;
	logic [RES_W-1:0] result_q;

	// subscription state
	logic                  have_prev_q;
	logic [TIME_BITS-1:0]  last_time_q;
	logic [FW-1:0]         last_state_q, last_seq_q, last_rev_q, last_ttl_q;
	logic [DW-1:0]         last_digest_q;
	logic                  deadline_set_q;
	logic [TIME_BITS-1:0]  deadline_q;
	logic                  expiry_done_q;
	logic [COUNTER_BITS-1:0] cnt_q [NC];

	logic advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = status_q;
	assign m_axis_tdata  = {{(OUT_W-RES_W){1'b0}}, result_q};

	// field unpacking
	logic [TIME_BITS-1:0] t;
	logic [FW-1:0]        st, sq, rev, ttl, btag, stag;
	logic [DW-1:0]        dig;
	logic [CW-1:0]        cidx;

	assign t    = data_s1[TIME_BITS-1:0];
	assign st   = data_s1[TIME_BITS +: FW];
	assign sq   = data_s1[TIME_BITS + FW +: FW];
	assign rev  = data_s1[TIME_BITS + 2*FW +: FW];
	assign ttl  = data_s1[TIME_BITS + 3*FW +: FW];
	assign dig  = data_s1[TIME_BITS + 4*FW +: DW];
	assign btag = data_s1[TIME_BITS + 4*FW + DW +: FW];
	assign stag = data_s1[TIME_BITS + 5*FW + DW +: FW];
	assign cidx = data_s1[TIME_BITS + 6*FW + DW +: CW];

	// per-item decisions
	logic                 time_back, id_bad, reached, due;
	logic                 last_max, st_ne, is_next, is_jump;
	logic [FW-1:0]        next_st, delta;
	logic [TIME_BITS:0]   dl_sum;
	logic [TIME_BITS-1:0] dl_new;
	logic                 vchg;

	always_comb begin
		time_back = have_prev_q && (t < last_time_q);
		id_bad    = (check_enable_q[0] && (btag != exp_block_q)) ||
		            (check_enable_q[1] && (stag != exp_set_q)) ||
		            (check_enable_q[2] && (rev != exp_rev_q));
		reached   = deadline_set_q && (t >= deadline_q);
		due       = reached && !expiry_done_q;
		last_max  = (last_state_q == {FW{1'b1}});
		next_st   = last_max ? {{(FW-1){1'b0}}, 1'b1} : last_state_q + {{(FW-1){1'b0}}, 1'b1};
		st_ne     = (st != last_state_q);
		is_next   = (st == next_st);
		is_jump   = last_max ? (st > {{(FW-1){1'b0}}, 1'b1}) : (st > last_state_q);
		delta     = sq - last_seq_q;
		dl_sum    = {1'b0, t} + (TIME_BITS + 1)'(ttl);
		dl_new    = dl_sum[TIME_BITS] ? TIME_MAX : dl_sum[TIME_BITS-1:0];
		vchg      = have_prev_q && (dig != last_digest_q);
	end

	// result and next state
	gss_pkg::status_t        status_d;
	logic [4:0]              flags_d;
	logic [FW-2:0]           missed_d;
	logic [TIME_BITS-1:0]    aux_d;
	logic [FW-1:0]           rst_d, rsq_d, rttl_d;
	logic [NC-1:0]           bump;
	logic                    accept_frame, clear_all;
	logic                    dl_set_d;
	logic [TIME_BITS-1:0]    dl_d;
	logic                    exp_done_d;
	logic [63:0]             cnt_ext;

	always_comb begin
		status_d     = gss_pkg::ST_NONE;
		flags_d      = '0;
		missed_d     = '0;
		aux_d        = '0;
		rst_d        = '0;
		rsq_d        = '0;
		rttl_d       = '0;
		bump         = '0;
		accept_frame = 1'b0;
		clear_all    = 1'b0;
		dl_set_d     = deadline_set_q;
		dl_d         = deadline_q;
		exp_done_d   = expiry_done_q;
		cnt_ext      = '0;
		case (op_s1)
			gss_pkg::OP_FRAME: begin
				if (time_back) begin
					status_d = gss_pkg::ST_TIME_BACK;
				end else if (id_bad) begin
					status_d = gss_pkg::ST_IDENTITY;
					bump[gss_pkg::CNT_IDENTITY] = 1'b1;
				end else begin
					accept_frame = 1'b1;
					flags_d[gss_pkg::FLG_EXPIRED_BEFORE] = reached;
					bump[gss_pkg::CNT_EXPIRED]  = due;
					bump[gss_pkg::CNT_ACCEPTED] = 1'b1;
					if (have_prev_q) begin
						aux_d = t - last_time_q;
					end
					if (!have_prev_q) begin
						status_d = gss_pkg::ST_FIRST;
					end else if (st_ne) begin
						if (is_next) begin
							status_d = gss_pkg::ST_CHANGE;
							bump[gss_pkg::CNT_CHANGE] = 1'b1;
						end else if (is_jump) begin
							status_d = gss_pkg::ST_JUMP;
							bump[gss_pkg::CNT_JUMP] = 1'b1;
						end else begin
							status_d = gss_pkg::ST_STATE_BACK;
							bump[gss_pkg::CNT_ST_BACK] = 1'b1;
						end
						flags_d[gss_pkg::FLG_CHANGE_SEQ] = is_next || is_jump ? (sq != '0) : 1'b0;
					end else if (delta == '0) begin
						status_d = gss_pkg::ST_DUPLICATE;
						bump[gss_pkg::CNT_DUP] = 1'b1;
					end else if (delta < gss_pkg::HALF_RANGE) begin
						if (delta == {{(FW-1){1'b0}}, 1'b1}) begin
							status_d = gss_pkg::ST_RETRANSMIT;
							bump[gss_pkg::CNT_RETX] = 1'b1;
						end else begin
							status_d = gss_pkg::ST_SEQ_GAP;
							bump[gss_pkg::CNT_GAP] = 1'b1;
							missed_d = delta[FW-2:0] - {{(FW-2){1'b0}}, 1'b1};
						end
					end else begin
						status_d = gss_pkg::ST_SEQ_BACK;
						bump[gss_pkg::CNT_SEQ_BACK] = 1'b1;
					end
					flags_d[gss_pkg::FLG_VALUES] = vchg;
					flags_d[gss_pkg::FLG_SAME_STATE] = vchg && !st_ne;
					bump[gss_pkg::CNT_SAME_ST] = vchg && !st_ne;
					flags_d[gss_pkg::FLG_REVISION] = have_prev_q && (rev != last_rev_q);
					exp_done_d = 1'b0;
					dl_set_d   = (ttl != '0);
					dl_d       = (ttl != '0) ? dl_new : '0;
				end
			end
			gss_pkg::OP_EXPIRY: begin
				if (due) begin
					status_d   = gss_pkg::ST_EXPIRED;
					exp_done_d = 1'b1;
					bump[gss_pkg::CNT_EXPIRED] = 1'b1;
					rst_d  = last_state_q;
					rsq_d  = last_seq_q;
					rttl_d = last_ttl_q;
				end
			end
			gss_pkg::OP_READ: begin
				status_d = gss_pkg::ST_COUNTER;
				if (cidx < CW'(NC)) begin
					cnt_ext = 64'(cnt_q[cidx]);
				end
				aux_d = cnt_ext[TIME_BITS-1:0];
			end
			gss_pkg::OP_CLEAR: begin
				status_d   = gss_pkg::ST_CLEARED;
				clear_all  = 1'b1;
				dl_set_d   = 1'b0;
				dl_d       = '0;
				exp_done_d = 1'b0;
			end
			default: begin
				status_d = gss_pkg::ST_NONE;
			end
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_enable_q <= '0;
			exp_block_q    <= '0;
			exp_set_q      <= '0;
			exp_rev_q      <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gss_pkg::REG_CHECK_ENABLE: check_enable_q <= cfg_data[2:0];
				gss_pkg::REG_BLOCK_TAG:    exp_block_q    <= cfg_data;
				gss_pkg::REG_SET_TAG:      exp_set_q      <= cfg_data;
				gss_pkg::REG_REVISION:     exp_rev_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1   <= gss_pkg::op_t'(s_axis_tuser);
			data_s1 <= s_axis_tdata;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			result_q <= {rttl_d, rsq_d, rst_d, dl_d, dl_set_d, aux_d, missed_d, flags_d};
		end
	end

	// subscription state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_prev_q    <= 1'b0;
			last_time_q    <= '0;
			last_state_q   <= '0;
			last_seq_q     <= '0;
			last_rev_q     <= '0;
			last_ttl_q     <= '0;
			last_digest_q  <= '0;
			deadline_set_q <= 1'b0;
			deadline_q     <= '0;
			expiry_done_q  <= 1'b0;
		end else if (advance) begin
			deadline_set_q <= dl_set_d;
			deadline_q     <= dl_d;
			expiry_done_q  <= exp_done_d;
			if (clear_all) begin
				have_prev_q   <= 1'b0;
				last_time_q   <= '0;
				last_state_q  <= '0;
				last_seq_q    <= '0;
				last_rev_q    <= '0;
				last_ttl_q    <= '0;
				last_digest_q <= '0;
			end else if (accept_frame) begin
				have_prev_q   <= 1'b1;
				last_time_q   <= t;
				last_state_q  <= st;
				last_seq_q    <= sq;
				last_rev_q    <= rev;
				last_ttl_q    <= ttl;
				last_digest_q <= dig;
			end
		end
	end

	// statistics counters, wrapping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NC; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (advance) begin
			for (int i = 0; i < NC; i++) begin
				if (clear_all) begin
					cnt_q[i] <= '0;
				end else if (bump[i]) begin
					cnt_q[i] <= cnt_q[i] + CNT_ONE;
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/gss_checker.sv @@
// Port-level checker for the GOOSE subscription supervisor, bound to the top.
// Depends on gss_pkg for status codes.
`default_nettype none

module gss_checker #(
	parameter int TIME_BITS = 48,
	localparam int OUT_W = ((2 * TIME_BITS + 5 + 31 + 1 + 3 * 32 + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata,
	input wire logic [3:0]       m_axis_tuser
);

	localparam int ARM_BIT = 36 + TIME_BITS;
	localparam int DL_LSB  = 37 + TIME_BITS;
	localparam int REP_LSB = 37 + 2 * TIME_BITS;

	logic             armed;
	logic [TIME_BITS-1:0] dl;
	logic [95:0]      reports;
	logic [4:0]       flags;
	logic [30:0]      missed;
	logic             frame_ok;

	assign armed    = m_axis_tdata[ARM_BIT];
	assign dl       = m_axis_tdata[DL_LSB +: TIME_BITS];
	assign reports  = m_axis_tdata[REP_LSB +: 96];
	assign flags    = m_axis_tdata[4:0];
	assign missed   = m_axis_tdata[35:5];
	assign frame_ok = (m_axis_tuser == gss_pkg::ST_FIRST) ||
	                  (m_axis_tuser == gss_pkg::ST_RETRANSMIT) ||
	                  (m_axis_tuser == gss_pkg::ST_CHANGE) || (m_axis_tuser == gss_pkg::ST_JUMP) ||
	                  (m_axis_tuser == gss_pkg::ST_STATE_BACK) ||
	                  (m_axis_tuser == gss_pkg::ST_DUPLICATE) ||
	                  (m_axis_tuser == gss_pkg::ST_SEQ_GAP) ||
	                  (m_axis_tuser == gss_pkg::ST_SEQ_BACK);

	// hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
		$stable(m_axis_tuser))
		else $error("result changed while stalled");

	// expiry report only on an expiry event
	a_report_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != gss_pkg::ST_EXPIRED) |-> reports == '0)
		else $error("expiry report outside expiry event");

	// disarmed deadline reads as zero
	a_deadline_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !armed |-> dl == '0)
		else $error("deadline nonzero while disarmed");

	// flags and missed count only on accepted-frame results
	a_flags_frame: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !frame_ok |-> flags == '0 && missed == '0)
		else $error("flags or missed count on a non-frame result");

	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == gss_pkg::ST_CLEARED) |-> !armed)
		else $error("deadline armed after clear");

endmodule

bind goose_subscription_supervisor gss_checker #(
	.TIME_BITS(TIME_BITS)
) u_gss_checker (.*);

`default_nettype wire
